>>> hdl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and codes for the compacting array list unit.
// ----------------------------------------------------------------------------
package cal_pkg;

	localparam int unsigned DEPTH = 8;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = 4;
	localparam int unsigned RND_W = $clog2(DEPTH);

	localparam logic [2:0] FN_APPEND    = 3'd0;
	localparam logic [2:0] FN_DEL_POS   = 3'd1;
	localparam logic [2:0] FN_DEL_FIRST = 3'd2;
	localparam logic [2:0] FN_DEL_ALL   = 3'd3;
	localparam logic [2:0] FN_SEARCH    = 3'd4;
	localparam logic [2:0] FN_READ      = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADPOS   = 3'd4;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] value;
		logic [3:0] position;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       found;
		logic [7:0] value_out;
		logic [3:0] count_out;
		logic [3:0] removed;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_IDLE,
		CMD_WRITE,
		CMD_MARK,
		CMD_STEP
	} cell_op_t;

	typedef enum logic [1:0] {
		DEL_NONE,
		DEL_POS,
		DEL_FIRST,
		DEL_ALL
	} del_kind_t;

	typedef struct packed {
		cell_op_t   op;
		del_kind_t  kind;
		logic [7:0] value;
		logic       phase;
	} cell_cmd_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_COMPACT
	} fsm_state_t;

endpackage

>>> hdl/compacting_array_list_unit.sv
// ----------------------------------------------------------------------------
// compacting_array_list_unit
// Bounded ordered byte list held in a row of cells, with in-place compaction.
// ----------------------------------------------------------------------------
// Append, search, read and rejected operations return their registered result
// in the cycle after the accepted beat. A successful delete also does, but the
// row of cells then runs DEPTH odd-even exchange passes to close the gaps, and
// no new beat is accepted until those passes are done.
// A new beat is taken while the previous result waits if that result is taken
// in the same cycle.
module compacting_array_list_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cal_pkg::rsp_t rsp
);
	import cal_pkg::*;

	fsm_state_t          state_q, state_d;
	logic [RND_W-1:0]    round_q;
	logic [CNT_W-1:0]    count_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q, rsp_d;
	cell_cmd_t           cmd;
	logic                fire;

	logic [DEPTH-1:0]    filled, pos_hit, write_hit, hole_vec, match_vec, mark_vec;
	logic [DEPTH:0]      prior;
	logic [7:0]          data_vec [DEPTH];
	logic [CNT_W-1:0]    pos_m1, mark_cnt;
	logic                pos_ok, found, is_full, is_empty;
	logic [7:0]          read_data;
	cell_op_t            op_d;

	assign fire      = req_valid && req_ready;
	assign pos_m1    = req.position - CNT_W'(1);
	assign pos_ok    = (req.position != '0) && (req.position <= count_q);
	assign is_full   = count_q >= CNT_W'(DEPTH);
	assign is_empty  = count_q == '0;
	assign found     = |match_vec;
	assign read_data = data_vec[pos_m1[IDX_W-1:0]];
	assign mark_cnt  = CNT_W'($countones(mark_vec));
	assign prior[0]  = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);
		logic [7:0] left_data, right_data;
		logic       left_hole, right_hole;

		assign filled[i]    = SLOT < count_q;
		assign pos_hit[i]   = pos_ok && (pos_m1 == SLOT);
		assign write_hit[i] = count_q == SLOT;

		if (i == 0) begin : g_first
			assign left_data = data_vec[i];
			assign left_hole = 1'b0;
		end else begin : g_mid_l
			assign left_data = data_vec[i-1];
			assign left_hole = hole_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = data_vec[i];
			assign right_hole = 1'b1;
		end else begin : g_mid_r
			assign right_data = data_vec[i+1];
			assign right_hole = hole_vec[i+1];
		end

		cal_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.filled     (filled[i]),
			.pos_hit    (pos_hit[i]),
			.write_hit  (write_hit[i]),
			.odd        (SLOT[0]),
			.left_data  (left_data),
			.left_hole  (left_hole),
			.right_data (right_data),
			.right_hole (right_hole),
			.prior_in   (prior[i]),
			.data       (data_vec[i]),
			.hole       (hole_vec[i]),
			.match      (match_vec[i]),
			.mark       (mark_vec[i]),
			.prior_out  (prior[i+1])
		);
	end

	always_comb begin
		rsp_d.status    = ST_OK;
		rsp_d.found     = found;
		rsp_d.value_out = '0;
		rsp_d.count_out = count_q;
		rsp_d.removed   = '0;
		op_d            = CMD_IDLE;
		case (req.func) inside
			FN_APPEND: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end else begin
					op_d            = CMD_WRITE;
					rsp_d.count_out = count_q + CNT_W'(1);
				end
			end
			FN_DEL_POS: begin
				if (is_empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (!pos_ok) begin
					rsp_d.status = ST_BADPOS;
				end else begin
					op_d            = CMD_MARK;
					rsp_d.value_out = read_data;
				end
			end
			FN_DEL_FIRST, FN_DEL_ALL: begin
				if (is_empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (!found) begin
					rsp_d.status = ST_NOTFOUND;
				end else begin
					op_d            = CMD_MARK;
					rsp_d.value_out = req.value;
				end
			end
			FN_SEARCH: begin
				rsp_d.status = found ? ST_OK : ST_NOTFOUND;
			end
			FN_READ: begin
				if (!pos_ok) begin
					rsp_d.status = ST_BADPOS;
				end else begin
					rsp_d.value_out = read_data;
				end
			end
			default: begin
			end
		endcase
		if (op_d == CMD_MARK) begin
			rsp_d.removed   = mark_cnt;
			rsp_d.count_out = count_q - mark_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.value   = req.value;
		cmd.phase   = round_q[0];
		cmd.op      = CMD_IDLE;
		unique case (req.func)
			FN_DEL_POS:   cmd.kind = DEL_POS;
			FN_DEL_FIRST: cmd.kind = DEL_FIRST;
			FN_DEL_ALL:   cmd.kind = DEL_ALL;
			default:      cmd.kind = DEL_NONE;
		endcase
		unique case (state_q)
			FSM_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				if (req_valid && req_ready) begin
					cmd.op = op_d;
					if (op_d == CMD_MARK) begin
						state_d = FSM_COMPACT;
					end
				end
			end
			FSM_COMPACT: begin
				cmd.op = CMD_STEP;
				if (round_q == RND_W'(DEPTH - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == FSM_COMPACT) begin
				round_q <= round_q + RND_W'(1);
			end else begin
				round_q <= '0;
			end
			if (fire) begin
				count_q     <= rsp_d.count_out;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count exceeds list depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted beat produced no result");

	a_no_accept_compact: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_COMPACT |-> !req_ready)
		else $error("beat accepted during compaction");

	a_count_matches_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && $past(req_valid && req_ready) |-> rsp_q.count_out == count_q)
		else $error("reported count differs from stored count");
`endif

endmodule

>>> hdl/cal_cell.sv
// ----------------------------------------------------------------------------
// cal_cell
// One list slot: holds an entry and a hole flag, marks itself for removal
// and exchanges with a neighbor during compaction passes.
// ----------------------------------------------------------------------------
module cal_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  cal_pkg::cell_cmd_t  cmd,
	input  logic                filled,
	input  logic                pos_hit,
	input  logic                write_hit,
	input  logic                odd,
	input  logic [7:0]          left_data,
	input  logic                left_hole,
	input  logic [7:0]          right_data,
	input  logic                right_hole,
	input  logic                prior_in,
	output logic [7:0]          data,
	output logic                hole,
	output logic                match,
	output logic                mark,
	output logic                prior_out
);
	import cal_pkg::*;

	logic [7:0] data_q;
	logic       hole_q;
	logic       is_left;

	assign match     = filled && (data_q == cmd.value);
	assign prior_out = prior_in || match;
	assign is_left   = (odd == cmd.phase);
	assign data      = data_q;
	assign hole      = hole_q;

	always_comb begin
		unique case (cmd.kind)
			DEL_POS:   mark = filled && pos_hit;
			DEL_FIRST: mark = match && !prior_in;
			DEL_ALL:   mark = match;
			default:   mark = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q <= 1'b1;
		end else begin
			case (cmd.op)
				CMD_MARK: begin
					hole_q <= !filled || mark;
				end
				CMD_STEP: begin
					if (is_left && hole_q && !right_hole) begin
						hole_q <= 1'b0;
					end else if (!is_left && left_hole && !hole_q) begin
						hole_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_WRITE: begin
				if (write_hit) begin
					data_q <= cmd.value;
				end
			end
			CMD_STEP: begin
				if (is_left && hole_q && !right_hole) begin
					data_q <= right_data;
				end else if (!is_left && left_hole && !hole_q) begin
					data_q <= left_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> tb/sv/tb_compacting_array_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_array_list_unit
// Self-checking testbench for the compacting array list unit.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the empty and full list, position
// and value extremes, every operation and the spare function codes. A long
// random run follows, with values drawn mostly from a small pool or from the
// list itself so that matches, multiple deletes and compaction happen often.
// Each result is checked field by field with its table row or a list model.
// Both channels idle and stall at random, with calm phases in between.
// ----------------------------------------------------------------------------
module tb_compacting_array_list_unit;

	import cal_pkg::*;

	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;
	localparam int         RAND_BEATS = 1700;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t want;
	} step_row_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp;

	logic [7:0] list_mem [DEPTH];
	int         list_cnt;
	rsp_t       list_results_due [$];
	step_row_t  dir_rows [$];
	logic [7:0] val_pool [4];
	bit         calm;
	int         err_cnt;

	compacting_array_list_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb_compacting_array_list_unit: done, errors");
		$finish;
	end

	function automatic int pick_wait();
		return calm ? 0 : int'($urandom_range(0, 19));
	endfunction

	function automatic void list_drop(int slot);
		int k;
		for (k = slot; k + 1 < list_cnt; k++)
			list_mem[k] = list_mem[k + 1];
		list_cnt--;
	endfunction

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		bit   hit;
		int   k;
		hit = 1'b0;
		for (k = 0; k < list_cnt; k++)
			if (list_mem[k] == r.value)
				hit = 1'b1;
		o = '0;
		o.status = ST_OK;
		o.found = hit;
		case (r.func)
			FN_APPEND: begin
				if (list_cnt >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					list_mem[list_cnt] = r.value;
					list_cnt++;
				end
			end
			FN_DEL_POS: begin
				if (list_cnt == 0) begin
					o.status = ST_EMPTY;
				end else if (r.position == 0 || r.position > list_cnt) begin
					o.status = ST_BADPOS;
				end else begin
					o.value_out = list_mem[r.position - 1];
					list_drop(r.position - 1);
					o.removed = 4'd1;
				end
			end
			FN_DEL_FIRST: begin
				if (list_cnt == 0) begin
					o.status = ST_EMPTY;
				end else if (!hit) begin
					o.status = ST_NOTFOUND;
				end else begin
					for (k = 0; k < list_cnt; k++) begin
						if (list_mem[k] == r.value) begin
							list_drop(k);
							break;
						end
					end
					o.value_out = r.value;
					o.removed = 4'd1;
				end
			end
			FN_DEL_ALL: begin
				if (list_cnt == 0) begin
					o.status = ST_EMPTY;
				end else if (!hit) begin
					o.status = ST_NOTFOUND;
				end else begin
					k = 0;
					while (k < list_cnt) begin
						if (list_mem[k] == r.value) begin
							list_drop(k);
							o.removed++;
						end else begin
							k++;
						end
					end
					o.value_out = r.value;
				end
			end
			FN_SEARCH: begin
				o.status = hit ? ST_OK : ST_NOTFOUND;
			end
			FN_READ: begin
				if (r.position == 0 || r.position > list_cnt)
					o.status = ST_BADPOS;
				else
					o.value_out = list_mem[r.position - 1];
			end
			default: begin
			end
		endcase
		o.count_out = list_cnt[3:0];
		return o;
	endfunction

	function automatic void add_row(logic [2:0] f, logic [7:0] v, logic [3:0] p, bit t,
			logic [2:0] st, logic fd, logic [7:0] vo, logic [3:0] c, logic [3:0] rm);
		step_row_t row;
		row.beat = '{func: f, value: v, position: p};
		row.typed = t;
		row.want = '{status: st, found: fd, value_out: vo, count_out: c, removed: rm};
		dir_rows.push_back(row);
	endfunction

	task automatic send_beat(req_t beat, bit typed, rsp_t want);
		int gap;
		gap = pick_wait();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		do @(negedge clk); while (!req_ready);
		if (typed) begin
			void'(list_apply(beat));
			list_results_due.push_back(want);
		end else begin
			list_results_due.push_back(list_apply(beat));
		end
		@(posedge clk);
	endtask

	initial begin
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pick_wait();
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(negedge clk); while (!rsp_valid);
			@(posedge clk);
		end
	end

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (list_results_due.size() == 0) begin
				$display("%0t: result beat with none expected: %p", $time, rsp);
				err_cnt++;
			end else begin
				want = list_results_due.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					err_cnt++;
				end
				if (rsp.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d",
						$time, want.found, rsp.found);
					err_cnt++;
				end
				if (rsp.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h actual %h",
						$time, want.value_out, rsp.value_out);
					err_cnt++;
				end
				if (rsp.count_out !== want.count_out) begin
					$display("%0t: count_out expected %0d actual %0d",
						$time, want.count_out, rsp.count_out);
					err_cnt++;
				end
				if (rsp.removed !== want.removed) begin
					$display("%0t: removed expected %0d actual %0d",
						$time, want.removed, rsp.removed);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		req_t beat;
		int   n;
		int   r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		err_cnt = 0;
		calm = 1'b0;
		list_cnt = 0;
		foreach (list_mem[k])
			list_mem[k] = '0;

		add_row(FN_READ,      8'h00, 4'd1,  1'b1, ST_BADPOS,   1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_POS,   8'h00, 4'd1,  1'b1, ST_EMPTY,    1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_FIRST, 8'h00, 4'd0,  1'b1, ST_EMPTY,    1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_ALL,   8'hFF, 4'd15, 1'b1, ST_EMPTY,    1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_SEARCH,    8'hFF, 4'd0,  1'b1, ST_NOTFOUND, 1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_SPARE6,    8'h00, 4'd15, 1'b1, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_APPEND,    8'h00, 4'd0,  1'b1, ST_OK,       1'b0, 8'h00, 4'd1, 4'd0);
		add_row(FN_APPEND,    8'hFF, 4'd15, 1'b1, ST_OK,       1'b0, 8'h00, 4'd2, 4'd0);
		add_row(FN_APPEND,    8'hFF, 4'd0,  1'b1, ST_OK,       1'b1, 8'h00, 4'd3, 4'd0);
		add_row(FN_APPEND,    8'h5A, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_APPEND,    8'hFF, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_APPEND,    8'hA5, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_APPEND,    8'h00, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_APPEND,    8'hFF, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_APPEND,    8'h01, 4'd0,  1'b1, ST_FULL,     1'b0, 8'h00, 4'd8, 4'd0);
		add_row(FN_READ,      8'h00, 4'd0,  1'b1, ST_BADPOS,   1'b1, 8'h00, 4'd8, 4'd0);
		add_row(FN_READ,      8'h01, 4'd8,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_SEARCH,    8'h5A, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_SPARE7,    8'hFF, 4'd15, 1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_FIRST, 8'hFF, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_ALL,   8'hFF, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_POS,   8'h00, 4'd1,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_FIRST, 8'h77, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_ALL,   8'h77, 4'd0,  1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);
		add_row(FN_DEL_POS,   8'h00, 4'd15, 1'b0, ST_OK,       1'b0, 8'h00, 4'd0, 4'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		for (n = 0; n < RAND_BEATS; n++) begin
			if (n % 150 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (n % 40 == 0)
				foreach (val_pool[k])
					val_pool[k] = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 5)
				beat.func = 3'($urandom_range(0, 7));
			else if (r < 40)
				beat.func = FN_APPEND;
			else if (r < 53)
				beat.func = FN_DEL_POS;
			else if (r < 66)
				beat.func = FN_DEL_FIRST;
			else if (r < 78)
				beat.func = FN_DEL_ALL;
			else if (r < 90)
				beat.func = FN_SEARCH;
			else
				beat.func = FN_READ;
			r = $urandom_range(0, 99);
			if (r < 15)
				beat.value = 8'($urandom_range(0, 255));
			else if (r < 60 && list_cnt > 0 && beat.func != FN_APPEND)
				beat.value = list_mem[$urandom_range(0, list_cnt - 1)];
			else
				beat.value = val_pool[$urandom_range(0, 3)];
			if ((beat.func == FN_DEL_POS || beat.func == FN_READ) && list_cnt > 0
					&& $urandom_range(0, 3) != 0)
				beat.position = 4'($urandom_range(1, list_cnt));
			else
				beat.position = 4'($urandom_range(0, 15));
			send_beat(beat, 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (list_results_due.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 4) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_compacting_array_list_unit: done, clean");
		else
			$display("tb_compacting_array_list_unit: done, errors");
		$finish;
	end

endmodule
